@@ rtl/core/salb_pkg.sv @@
// Shared types, codes and constants for the suffix array LCP builder.
`timescale 1ns / 1ps

package salb_pkg;

    // Field widths
    localparam int POS_W = 12;
    localparam int SYM_W = 8;
    localparam int LEN_W = 13;

    // Store capacity and parameter default
    localparam int STORE_CAP       = 4096;
    localparam int MAX_LEN_DEFAULT = 4096;

    // Saturation value for a stored LCP
    localparam logic [POS_W-1:0] LCP_MAX = 12'hFFF;

    // Command codes
    localparam logic [1:0] CMD_LOAD_TEXT = 2'd0;
    localparam logic [1:0] CMD_LOAD_SA   = 2'd1;
    localparam logic [1:0] CMD_COMPUTE   = 2'd2;
    localparam logic [1:0] CMD_READ_LCP  = 2'd3;

    // Result kinds
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_LCP  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_text;
        logic wr_sa;
        logic rd_lcp;
        logic start_comp;
        logic clr_i;
        logic inv_rd;
        logic inv_wr;
        logic scan_rd;
        logic scan_j;
        logic scan_k;
        logic cmp_rd;
        logic inc_l;
        logic lcp_wr;
        logic next_i;
        logic emit_read;
        logic emit_done;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic i_lt_n;
        logic j_ok;
        logic cmp_in;
        logic text_eq;
    } dp_status_t;

endpackage

@@ rtl/core/salb_ctrl.sv @@
// Controller state machine that sequences loads, reads and the LCP computation.
`timescale 1ns / 1ps

module salb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            cmd,
    output logic                  busy,
    input  salb_pkg::dp_status_t  status,
    output salb_pkg::ctrl_cmd_t   cmds
);
    import salb_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INV_RD  = 4'd1;
    localparam logic [3:0] ST_INV_WR  = 4'd2;
    localparam logic [3:0] ST_SCAN_RD = 4'd3;
    localparam logic [3:0] ST_SCAN_J  = 4'd4;
    localparam logic [3:0] ST_SCAN_K  = 4'd5;
    localparam logic [3:0] ST_CMP_RD  = 4'd6;
    localparam logic [3:0] ST_CMP_EQ  = 4'd7;
    localparam logic [3:0] ST_LCP_WR  = 4'd8;
    localparam logic [3:0] ST_RD_WAIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Decode state into datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmds       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_LOAD_TEXT: cmds.wr_text = 1'b1;
                        CMD_LOAD_SA:   cmds.wr_sa = 1'b1;
                        CMD_COMPUTE:
                        begin
                            cmds.start_comp = 1'b1;
                            state_next      = ST_INV_RD;
                        end
                        CMD_READ_LCP:
                        begin
                            cmds.rd_lcp = 1'b1;
                            state_next  = ST_RD_WAIT;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                cmds.emit_read = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_INV_RD:
            begin
                if (status.i_lt_n)
                begin
                    cmds.inv_rd = 1'b1;
                    state_next  = ST_INV_WR;
                end
                else
                begin
                    cmds.clr_i = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_INV_WR:
            begin
                cmds.inv_wr = 1'b1;
                state_next  = ST_INV_RD;
            end
            ST_SCAN_RD:
            begin
                if (status.i_lt_n)
                begin
                    cmds.scan_rd = 1'b1;
                    state_next   = ST_SCAN_J;
                end
                else
                begin
                    cmds.emit_done = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SCAN_J:
            begin
                if (status.j_ok)
                begin
                    cmds.scan_j = 1'b1;
                    state_next  = ST_SCAN_K;
                end
                else
                begin
                    cmds.next_i = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_SCAN_K:
            begin
                cmds.scan_k = 1'b1;
                state_next  = ST_CMP_RD;
            end
            ST_CMP_RD:
            begin
                if (status.cmp_in)
                begin
                    cmds.cmp_rd = 1'b1;
                    state_next  = ST_CMP_EQ;
                end
                else
                begin
                    state_next = ST_LCP_WR;
                end
            end
            ST_CMP_EQ:
            begin
                if (status.text_eq)
                begin
                    cmds.inc_l = 1'b1;
                    state_next = ST_CMP_RD;
                end
                else
                begin
                    state_next = ST_LCP_WR;
                end
            end
            ST_LCP_WR:
            begin
                cmds.lcp_wr = 1'b1;
                state_next  = ST_SCAN_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/salb_datapath.sv @@
// Datapath: text, suffix array, inverse and LCP memories, scan counters, result registers.
`timescale 1ns / 1ps

module salb_datapath #(
    parameter int MAX_LEN = salb_pkg::MAX_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [salb_pkg::POS_W-1:0]  position,
    input  logic [salb_pkg::SYM_W-1:0]  symbol,
    input  logic [salb_pkg::POS_W-1:0]  suffix_start,
    input  logic                        cfg_we,
    input  logic [salb_pkg::LEN_W-1:0]  cfg_wdata,
    input  salb_pkg::ctrl_cmd_t         cmds,
    output salb_pkg::dp_status_t        status,
    output logic                        result_strobe,
    output logic                        kind,
    output logic [salb_pkg::POS_W-1:0]  rank,
    output logic [salb_pkg::POS_W-1:0]  lcp_value
);
    import salb_pkg::*;

    localparam int DEPTH = (MAX_LEN < STORE_CAP) ? MAX_LEN : STORE_CAP;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

    // Memories
    logic [SYM_W-1:0] text_mem [DEPTH];
    logic [POS_W-1:0] r2s_mem  [DEPTH];
    logic [POS_W-1:0] s2r_mem  [DEPTH];
    logic [POS_W-1:0] lcp_mem  [DEPTH];

    // Registered read data
    logic [SYM_W-1:0] text_a_reg;
    logic [SYM_W-1:0] text_b_reg;
    logic [POS_W-1:0] r2s_rd_reg;
    logic [POS_W-1:0] s2r_rd_reg;
    logic [POS_W-1:0] lcp_rd_reg;

    // Scan state
    logic [LEN_W-1:0] text_length_reg;
    logic [LEN_W-1:0] scan_index_reg;
    logic [LEN_W-1:0] scan_index_next;
    logic [LEN_W-1:0] match_length_reg;
    logic [LEN_W-1:0] match_length_next;
    logic [POS_W-1:0] j_reg;
    logic [POS_W-1:0] k_reg;

    // Read command hold
    logic [POS_W-1:0] rank_hold_reg;
    logic             rd_ok_reg;

    // Result registers
    logic             result_strobe_reg;
    logic             kind_reg;
    logic [POS_W-1:0] rank_reg;
    logic [POS_W-1:0] lcp_value_reg;

    logic [LEN_W-1:0] n_len;
    logic [LEN_W:0]   sum_k;
    logic [LEN_W:0]   sum_i;
    logic [POS_W-1:0] j_prev;
    logic [POS_W-1:0] lcp_sat;
    logic             pos_in_store;
    logic             pos_rd_ok;
    logic [AW-1:0]    r2s_rd_addr;

    // Derive effective length, addresses and status
    assign n_len        = (text_length_reg < DEPTH_L) ? text_length_reg : DEPTH_L;
    assign sum_k        = {2'b00, k_reg} + {1'b0, match_length_reg};
    assign sum_i        = {1'b0, scan_index_reg} + {1'b0, match_length_reg};
    assign j_prev       = s2r_rd_reg - POS_W'(1);
    assign lcp_sat      = (match_length_reg > {1'b0, LCP_MAX}) ? LCP_MAX
                                                               : match_length_reg[POS_W-1:0];
    assign pos_in_store = ({1'b0, position} < DEPTH_L);
    assign pos_rd_ok    = (position != '0) && ({1'b0, position} < n_len);
    assign r2s_rd_addr  = cmds.scan_j ? j_prev[AW-1:0] : scan_index_reg[AW-1:0];

    assign status.i_lt_n  = (scan_index_reg < n_len);
    assign status.j_ok    = (s2r_rd_reg != '0) && ({1'b0, s2r_rd_reg} < n_len);
    assign status.cmp_in  = (sum_k < {1'b0, n_len}) && (sum_i < {1'b0, n_len});
    assign status.text_eq = (text_a_reg == text_b_reg);

    // Next values of the scan counters
    always_comb
    begin
        scan_index_next   = scan_index_reg;
        match_length_next = match_length_reg;
        if (cmds.start_comp)
        begin
            scan_index_next   = '0;
            match_length_next = '0;
        end
        else if (cmds.clr_i)
        begin
            scan_index_next = '0;
        end
        else if (cmds.inv_wr || cmds.next_i)
        begin
            scan_index_next = scan_index_reg + LEN_W'(1);
        end
        else if (cmds.lcp_wr)
        begin
            scan_index_next   = scan_index_reg + LEN_W'(1);
            match_length_next = (match_length_reg != '0) ? match_length_reg - LEN_W'(1)
                                                         : '0;
        end
        else if (cmds.inc_l)
        begin
            match_length_next = match_length_reg + LEN_W'(1);
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_length_reg   <= LEN_W'(1);
            scan_index_reg    <= '0;
            match_length_reg  <= '0;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                text_length_reg <= cfg_wdata;
            end
            scan_index_reg    <= scan_index_next;
            match_length_reg  <= match_length_next;
            result_strobe_reg <= cmds.emit_read || cmds.emit_done;
        end
    end

    // Latch scan operands, read command and result payload
    always_ff @(posedge clk)
    begin
        if (cmds.scan_j)
        begin
            j_reg <= s2r_rd_reg;
        end
        if (cmds.scan_k)
        begin
            k_reg <= r2s_rd_reg;
        end
        if (cmds.rd_lcp)
        begin
            rank_hold_reg <= position;
            rd_ok_reg     <= pos_rd_ok;
        end
        if (cmds.emit_read)
        begin
            kind_reg      <= KIND_LCP;
            rank_reg      <= rank_hold_reg;
            lcp_value_reg <= rd_ok_reg ? lcp_rd_reg : '0;
        end
        else if (cmds.emit_done)
        begin
            kind_reg      <= KIND_DONE;
            rank_reg      <= '0;
            lcp_value_reg <= '0;
        end
    end

    // Text memory: load write, two compare reads
    always_ff @(posedge clk)
    begin
        if (cmds.wr_text && pos_in_store)
        begin
            text_mem[position[AW-1:0]] <= symbol;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmds.cmp_rd)
        begin
            text_a_reg <= text_mem[sum_k[AW-1:0]];
            text_b_reg <= text_mem[sum_i[AW-1:0]];
        end
    end

    // Suffix array memory: load write, read for inverse build and predecessor
    always_ff @(posedge clk)
    begin
        if (cmds.wr_sa && pos_in_store)
        begin
            r2s_mem[position[AW-1:0]] <= suffix_start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmds.inv_rd || cmds.scan_j)
        begin
            r2s_rd_reg <= r2s_mem[r2s_rd_addr];
        end
    end

    // Inverse memory: write during build, read during scan
    always_ff @(posedge clk)
    begin
        if (cmds.inv_wr && ({1'b0, r2s_rd_reg} < n_len))
        begin
            s2r_mem[r2s_rd_reg[AW-1:0]] <= scan_index_reg[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmds.scan_rd)
        begin
            s2r_rd_reg <= s2r_mem[scan_index_reg[AW-1:0]];
        end
    end

    // LCP memory: write per scanned position, read on command
    always_ff @(posedge clk)
    begin
        if (cmds.lcp_wr)
        begin
            lcp_mem[j_reg[AW-1:0]] <= lcp_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmds.rd_lcp && pos_rd_ok)
        begin
            lcp_rd_reg <= lcp_mem[position[AW-1:0]];
        end
    end

    assign result_strobe = result_strobe_reg;
    assign kind          = kind_reg;
    assign rank          = rank_reg;
    assign lcp_value     = lcp_value_reg;

endmodule

@@ rtl/core/suffix_array_lcp_builder_top.sv @@
// Top level of the suffix array LCP builder: controller plus datapath.
`timescale 1ns / 1ps

// Usage
//   Input transaction: start high while busy is low, with cmd, position, symbol and
//   suffix_start. Load text and load suffix array entries leave busy low and give no
//   result. A read LCP transaction holds busy in the read wait state; its result
//   passes through the LCP read register and then the result registers to
//   result_strobe, kind, rank and lcp_value, and no new transaction is accepted while
//   busy is high. Rank 0 and ranks at or past the text length read as zero.
//   A compute transaction first builds the inverse suffix array, then per text
//   position either skips it (rank 0) or compares symbols from the running match
//   length until a mismatch or the text end and writes the LCP; Kasai's bound keeps
//   the matches under 2n in total.
//   Compute ends with one result of kind 0, rank 0 and lcp_value 0.
//   Each result is valid for the single cycle that result_strobe is high; the receiver
//   cannot stall, so no result is held. cfg_we writes text_length from cfg_wdata; write
//   it only while the block is idle.
//   Reset (rst_n low) returns the controller to idle, sets text_length to 1 and clears
//   the running match length and scan index. Memory contents are not cleared.

module suffix_array_lcp_builder_top #(
    parameter int MAX_LEN = salb_pkg::MAX_LEN_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  cmd,
    input  logic [salb_pkg::POS_W-1:0]  position,
    input  logic [salb_pkg::SYM_W-1:0]  symbol,
    input  logic [salb_pkg::POS_W-1:0]  suffix_start,
    input  logic                        cfg_we,
    input  logic [salb_pkg::LEN_W-1:0]  cfg_wdata,
    output logic                        result_strobe,
    output logic                        kind,
    output logic [salb_pkg::POS_W-1:0]  rank,
    output logic [salb_pkg::POS_W-1:0]  lcp_value
);
    import salb_pkg::*;

    ctrl_cmd_t  cmds;
    dp_status_t status;

    // Sequence transactions
    salb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .status (status),
        .cmds   (cmds)
    );

    // Store and scan
    salb_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .position      (position),
        .symbol        (symbol),
        .suffix_start  (suffix_start),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmds          (cmds),
        .status        (status),
        .result_strobe (result_strobe),
        .kind          (kind),
        .rank          (rank),
        .lcp_value     (lcp_value)
    );

endmodule
